[hw/rtl/aiws_pkg.sv]
// Shared types and constants for the AEHA IR waveform sampler.
// Holds the item structs, register indexes, reset values and the sequencer states.
// No dependencies.
`default_nettype none

package aiws_pkg;

    // Field and state widths.
    localparam int ON_W       = 10;
    localparam int OFF_W      = 10;
    localparam int OFF3_W     = 12;
    localparam int TRAIL_W    = 14;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 14;
    localparam int ELAPSED_W  = 24;
    localparam int COUNT_W    = 11;
    localparam int DUR_W      = 14;
    localparam int RES_CNT_W  = 6;

    // At most this many result items are delivered for one input item.
    localparam int RESULT_LIMIT = 60;

    // Register reset values.
    localparam logic [ON_W-1:0]    ON_TIME_RESET   = 10'd488;
    localparam logic [OFF_W-1:0]   OFF_TIME_RESET  = 10'd464;
    localparam logic [OFF3_W-1:0]  OFF3_RESET      = 12'd1392;
    localparam logic [TRAIL_W-1:0] TRAIL_OFF_RESET = 14'd8000;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ON_TIME   = 2'd0,
        REG_OFF_TIME  = 2'd1,
        REG_TRAIL_OFF = 2'd2
    } cfg_reg_t;

    // Input item: one frame byte with its frame marks.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_byte;
        logic       last_byte;
    } in_item_t;

    // Result item: eight packed carrier samples.
    typedef struct packed {
        logic [7:0] sample_byte;
        logic [7:0] byte_index;
        logic       run_last;
    } out_item_t;

    // Sequencer states: idle, one per pulse segment, flush and wrap-up.
    typedef enum logic [8:0] {
        S_IDLE      = 9'b000000001,
        S_LEAD_ON   = 9'b000000010,
        S_LEAD_OFF  = 9'b000000100,
        S_BIT_ON    = 9'b000001000,
        S_BIT_OFF   = 9'b000010000,
        S_TRAIL_ON  = 9'b000100000,
        S_TRAIL_OFF = 9'b001000000,
        S_FLUSH     = 9'b010000000,
        S_DONE      = 9'b100000000
    } seq_state_t;

endpackage

`default_nettype wire

[hw/rtl/aeha_ir_waveform_sampler_unit.sv]
// Top level of the AEHA IR waveform sampler: pulse sequencer, bit-serial sample packer
// and result output register. Depends on aiws_pkg.
`default_nettype none

// Channel   Direction  Handshake            Payload
// cfg       in         cfg_wr_en            cfg_index, cfg_data (on, off, trailer times)
// in        in         in_valid / in_stall  in_data  (data_byte, first_byte, last_byte)
// out       out        out_valid/ out_stall out_data (sample_byte, byte_index, run_last)
//
// An item runs through up to S pulse segments (16 for the data bits, plus 2 for the leader
// on a first byte and 2 for the trailer on a last byte); its samples are placed one per cycle
// by the sample shift register while no full output holds them; a flush pads the partial byte.
// A new item is taken only when the sequencer is back in idle.
// Reset clears the timing state and loads the register reset values; no clearing pass.
// A stalled output holds its item; the sequencer waits only when a finished byte, or the held
// result at wrap-up, must move into the output register and that register is still full.
module aeha_ir_waveform_sampler_unit
    import aiws_pkg::*;
#(
    parameter int MAX_SAMPLES      = 1920,
    parameter int SAMPLE_PERIOD_US = 100
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire in_item_t              in_data,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output out_item_t                  out_data
);

    // The sample boundary register holds (sample_count + 1) * period.
    localparam int BOUND_W = $clog2((MAX_SAMPLES + 8) * SAMPLE_PERIOD_US + 1);
    localparam int CMP_W   = (BOUND_W > ELAPSED_W) ? BOUND_W : ELAPSED_W;
    localparam logic [BOUND_W-1:0]   PERIOD    = BOUND_W'(SAMPLE_PERIOD_US);
    localparam logic [COUNT_W-1:0]   SC_MAX    = COUNT_W'(MAX_SAMPLES);
    localparam logic [RES_CNT_W-1:0] RES_LIMIT = RES_CNT_W'(RESULT_LIMIT);

    // Configuration registers.
    logic [ON_W-1:0]      on_reg, on_next;
    logic [OFF_W-1:0]     off_reg, off_next;
    logic [OFF3_W-1:0]    off3_reg, off3_next;
    logic [TRAIL_W-1:0]   trail_reg, trail_next;

    // Sequencer and timing state.
    seq_state_t           state_reg, state_next;
    logic                 adding_reg, adding_next;
    logic [ELAPSED_W-1:0] elapsed_reg, elapsed_next;
    logic [COUNT_W-1:0]   sc_reg, sc_next;
    logic [BOUND_W-1:0]   bound_reg, bound_next;
    logic [7:0]           buf_reg, buf_next;
    logic [7:0]           data_reg, data_next;
    logic [2:0]           bit_cnt_reg, bit_cnt_next;
    logic                 last_reg, last_next;
    logic [RES_CNT_W-1:0] res_cnt_reg, res_cnt_next;

    // Held result, whose last mark is known only once the next one arrives.
    logic                 pend_valid_reg, pend_valid_next;
    logic [7:0]           pend_byte_reg, pend_byte_next;
    logic [7:0]           pend_index_reg, pend_index_next;

    // Output register.
    logic                 out_valid_reg, out_valid_next;
    out_item_t            out_reg, out_next;

    // Datapath helpers.
    logic                 timed;
    logic                 level;
    logic [DUR_W-1:0]     dur;
    logic [ELAPSED_W:0]   sum;
    logic [ELAPSED_W-1:0] elapsed_sat;
    logic                 run_ready;
    logic                 want_sample;
    logic                 byte_done;
    logic                 keep;
    logic                 out_free;
    logic                 do_sample;
    logic                 push;
    logic [7:0]           new_byte;
    logic                 seg_end;

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // Segment decode: which states run a timed level, the level, and its duration.
    always_comb
    begin
        timed = 1'b1;
        level = 1'b0;
        dur   = '0;
        case (state_reg)
            S_LEAD_ON:
            begin
                level = 1'b1;
                dur   = DUR_W'({on_reg, 3'b000});
            end
            S_LEAD_OFF:
            begin
                dur = DUR_W'({off_reg, 2'b00});
            end
            S_BIT_ON:
            begin
                level = 1'b1;
                dur   = DUR_W'(on_reg);
            end
            S_BIT_OFF:
            begin
                dur = data_reg[0] ? DUR_W'(off3_reg) : DUR_W'(off_reg);
            end
            S_TRAIL_ON:
            begin
                level = 1'b1;
                dur   = DUR_W'(on_reg);
            end
            S_TRAIL_OFF:
            begin
                dur = trail_reg;
            end
            default:
            begin
                timed = 1'b0;
            end
        endcase
    end

    // Saturating time add and the sample boundary test.
    always_comb
    begin
        sum         = {1'b0, elapsed_reg} + (ELAPSED_W + 1)'(dur);
        elapsed_sat = sum[ELAPSED_W] ? {ELAPSED_W{1'b1}} : sum[ELAPSED_W-1:0];
        run_ready   = (sc_reg < SC_MAX) && (CMP_W'(bound_reg) <= CMP_W'(elapsed_reg));
    end

    // One sample per cycle; a finished byte may have to wait for the output register.
    always_comb
    begin
        want_sample = (timed && !adding_reg && run_ready)
                   || ((state_reg == S_FLUSH) && (sc_reg[2:0] != 3'd0));
        byte_done   = (sc_reg[2:0] == 3'd7);
        keep        = (res_cnt_reg < RES_LIMIT);
        out_free    = !out_valid_reg || !out_stall;
        do_sample   = want_sample && (!(byte_done && keep && pend_valid_reg) || out_free);
        new_byte    = {level, buf_reg[7:1]};
        seg_end     = timed && !adding_reg && !run_ready;
        push        = (do_sample && byte_done && keep && pend_valid_reg)
                   || ((state_reg == S_DONE) && pend_valid_reg && out_free);
    end

    // Next-state logic.
    always_comb
    begin
        on_next         = on_reg;
        off_next        = off_reg;
        off3_next       = off3_reg;
        trail_next      = trail_reg;
        state_next      = state_reg;
        adding_next     = adding_reg;
        elapsed_next    = elapsed_reg;
        sc_next         = sc_reg;
        bound_next      = bound_reg;
        buf_next        = buf_reg;
        data_next       = data_reg;
        bit_cnt_next    = bit_cnt_reg;
        last_next       = last_reg;
        res_cnt_next    = res_cnt_reg;
        pend_valid_next = pend_valid_reg;
        pend_byte_next  = pend_byte_reg;
        pend_index_next = pend_index_reg;
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;

        // Register writes; the off time also keeps its triple for a one bit.
        if (cfg_wr_en)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_ON_TIME:
                begin
                    on_next = cfg_data[ON_W-1:0];
                end
                REG_OFF_TIME:
                begin
                    off_next  = cfg_data[OFF_W-1:0];
                    off3_next = {2'b00, cfg_data[OFF_W-1:0]}
                              + {1'b0, cfg_data[OFF_W-1:0], 1'b0};
                end
                REG_TRAIL_OFF:
                begin
                    trail_next = cfg_data[TRAIL_W-1:0];
                end
                default:
                begin
                end
            endcase
        end

        // Accept an item and pick the first segment.
        if ((state_reg == S_IDLE) && in_valid)
        begin
            data_next    = in_data.data_byte;
            last_next    = in_data.last_byte;
            bit_cnt_next = 3'd0;
            res_cnt_next = '0;
            adding_next  = 1'b1;
            if (in_data.first_byte)
            begin
                elapsed_next = '0;
                sc_next      = '0;
                bound_next   = PERIOD;
                state_next   = S_LEAD_ON;
            end
            else
            begin
                state_next = S_BIT_ON;
            end
        end

        // First cycle of a timed segment advances the running time.
        if (timed && adding_reg)
        begin
            elapsed_next = elapsed_sat;
            adding_next  = 1'b0;
        end

        // Shift one sample into the packer; a full byte becomes the held result.
        if (do_sample)
        begin
            buf_next   = new_byte;
            sc_next    = sc_reg + COUNT_W'(1);
            bound_next = bound_reg + PERIOD;
            if (byte_done && keep)
            begin
                res_cnt_next    = res_cnt_reg + RES_CNT_W'(1);
                pend_valid_next = 1'b1;
                pend_byte_next  = new_byte;
                pend_index_next = sc_reg[COUNT_W-1:3];
            end
        end

        // Move on when the current segment has placed all of its samples.
        if (seg_end)
        begin
            adding_next = 1'b1;
            case (state_reg)
                S_LEAD_ON:
                begin
                    state_next = S_LEAD_OFF;
                end
                S_LEAD_OFF:
                begin
                    state_next = S_BIT_ON;
                end
                S_BIT_ON:
                begin
                    state_next = S_BIT_OFF;
                end
                S_BIT_OFF:
                begin
                    data_next    = {1'b0, data_reg[7:1]};
                    bit_cnt_next = bit_cnt_reg + 3'd1;
                    if (bit_cnt_reg == 3'd7)
                    begin
                        state_next = last_reg ? S_TRAIL_ON : S_DONE;
                    end
                    else
                    begin
                        state_next = S_BIT_ON;
                    end
                end
                S_TRAIL_ON:
                begin
                    state_next = S_TRAIL_OFF;
                end
                S_TRAIL_OFF:
                begin
                    state_next = S_FLUSH;
                end
                default:
                begin
                    state_next = S_DONE;
                end
            endcase
        end

        // Flush ends once the partial byte has been padded out.
        if ((state_reg == S_FLUSH) && (sc_reg[2:0] == 3'd0))
        begin
            state_next = S_DONE;
        end

        // Wrap-up: release the held result as the last of this item.
        if (state_reg == S_DONE)
        begin
            if (!pend_valid_reg)
            begin
                state_next = S_IDLE;
            end
            else if (out_free)
            begin
                pend_valid_next = 1'b0;
                state_next      = S_IDLE;
            end
        end

        // Output register.
        if (push)
        begin
            out_valid_next       = 1'b1;
            out_next.sample_byte = pend_byte_reg;
            out_next.byte_index  = pend_index_reg;
            out_next.run_last    = (state_reg == S_DONE);
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            on_reg         <= ON_TIME_RESET;
            off_reg        <= OFF_TIME_RESET;
            off3_reg       <= OFF3_RESET;
            trail_reg      <= TRAIL_OFF_RESET;
            state_reg      <= S_IDLE;
            adding_reg     <= 1'b0;
            elapsed_reg    <= '0;
            sc_reg         <= '0;
            bound_reg      <= PERIOD;
            res_cnt_reg    <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            on_reg         <= on_next;
            off_reg        <= off_next;
            off3_reg       <= off3_next;
            trail_reg      <= trail_next;
            state_reg      <= state_next;
            adding_reg     <= adding_next;
            elapsed_reg    <= elapsed_next;
            sc_reg         <= sc_next;
            bound_reg      <= bound_next;
            res_cnt_reg    <= res_cnt_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        buf_reg        <= buf_next;
        data_reg       <= data_next;
        bit_cnt_reg    <= bit_cnt_next;
        last_reg       <= last_next;
        pend_byte_reg  <= pend_byte_next;
        pend_index_reg <= pend_index_next;
        out_reg        <= out_next;
    end

    // The per-item result count never passes its limit.
    a_res_limit: assert property (@(posedge clk) disable iff (!rst_n)
        res_cnt_reg <= RES_LIMIT)
        else $error("result count above limit");

    // A result released in mid-item is never marked as the last one.
    a_mid_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (push && (state_reg != S_DONE)) |=> !out_reg.run_last)
        else $error("mid-item result marked last");

    // Running time only grows while an item is being worked on.
    a_time_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |=> (elapsed_reg >= $past(elapsed_reg)))
        else $error("running time went backwards");

    // After a flush the sample count sits on a byte boundary.
    a_flush_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_DONE) && last_reg) |-> (sc_reg[2:0] == 3'd0))
        else $error("sample count not byte aligned after flush");

endmodule

`default_nettype wire
